### rtl/pkbd_pkg.sv
// Package for the prefix key block decoder: widths, result kinds, error codes.
// No dependencies.
package pkbd_pkg;
  localparam int KEY_MAX_DEF     = 32;
  localparam int REGION_BITS_DEF = 16;
  localparam int CFG_W           = 16;
  localparam int IDX_W           = 16;
  localparam int KLEN_W          = 6;
  localparam int VLEN_W          = 16;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  localparam logic [1:0] ERR_HEADER  = 2'd0;
  localparam logic [1:0] ERR_OVERRUN = 2'd1;
  localparam logic [1:0] ERR_SHARED  = 2'd2;
  localparam logic [1:0] ERR_KEYOVF  = 2'd3;

  // Command from parser to emitter.
  typedef enum logic [2:0] {
    CMD_KEY    = 3'd0,
    CMD_VALUE  = 3'd1,
    CMD_DONE   = 3'd2,
    CMD_ERROR  = 3'd3,
    CMD_REPLAY = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  data;
    logic [15:0] idx;
    logic [5:0]  count;
    logic [5:0]  klen;
    logic [15:0] vlen;
    logic [1:0]  code;
    logic        tail_done;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] idx;
    logic [5:0]  klen;
    logic [15:0] vlen;
    logic [1:0]  code;
    logic        last;
  } res_t;
endpackage

### rtl/pkbd_if.sv
// Valid/ready channel interfaces for the decoder.
// No dependencies.
interface pkbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;
  modport source (output valid, data_byte, block_start, input ready);
  modport sink (input valid, data_byte, block_start, output ready);
endinterface

interface pkbd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [15:0] item_index;
  logic [5:0]  entry_key_length;
  logic [15:0] entry_value_length;
  logic [1:0]  error_code;
  logic        last_result;
  modport source (output valid, out_kind, out_byte, item_index, entry_key_length,
                  entry_value_length, error_code, last_result, input ready);
  modport sink (input valid, out_kind, out_byte, item_index, entry_key_length,
                entry_value_length, error_code, last_result, output ready);
endinterface

interface pkbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/pkbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pkbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/pkbd_fifo.sv
// Short command queue between parser and emitter.
// Depends on pkbd_pkg.
module pkbd_fifo
  import pkbd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);
  localparam int AW = $clog2(DEPTH);
  cmd_t         q_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        q_r[wp_r] <= push_cmd;
        wp_r      <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

### rtl/pkbd_parser.sv
// Front end: accepts bytes, decodes varint headers, checks them, writes keys.
// Issues commands to the emitter. Depends on pkbd_pkg.
module pkbd_parser
  import pkbd_pkg::*;
#(
  parameter int KEY_MAX     = KEY_MAX_DEF,
  parameter int REGION_BITS = REGION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_start,
  input  logic [CFG_W-1:0]  entries_end,
  output logic              push,
  output cmd_t              push_cmd,
  input  logic              q_full,
  input  logic              replay_done,
  output logic              key_we,
  output logic [5:0]        key_waddr
);
  typedef enum logic [2:0] {
    PH_SHARED, PH_UNSHARED, PH_VALLEN, PH_KEY, PH_VALUE
  } phase_t;

  phase_t            phase_r;
  logic [31:0]       acc_r;
  logic [2:0]        vcnt_r;
  logic [31:0]       sh_r, un_r;
  logic [5:0]        klen_r;
  logic [15:0]       vlen_r;
  logic [15:0]       left_r;
  logic [REGION_BITS-1:0] pos_r;
  logic              halt_r;
  logic [2:0]        pend_r, pend_nxt;

  // hold key bytes while a queued replay still reads the key RAM
  assign in_ready = !q_full && !(phase_r == PH_KEY && pend_r != '0);
  logic acc;
  assign acc = in_valid && in_ready;

  // effective state after optional block start
  phase_t e_phase;
  logic [31:0] e_acc;
  logic [2:0]  e_vcnt;
  logic [5:0]  e_klen;
  logic [REGION_BITS-1:0] e_pos;
  logic e_halt;

  always_comb begin
    e_phase = in_start ? PH_SHARED : phase_r;
    e_acc   = in_start ? '0 : acc_r;
    e_vcnt  = in_start ? '0 : vcnt_r;
    e_klen  = in_start ? '0 : klen_r;
    e_pos   = in_start ? '0 : pos_r;
    e_halt  = in_start ? 1'b0 : halt_r;
  end

  logic [32:0] pos_ext, next_ext, end_ext, remain;
  logic [31:0] acc_new, v;
  logic [2:0]  vcnt_inc;
  logic [32:0] body_sum;
  logic [32:0] key_sum;

  phase_t      phase_nxt;
  logic [31:0] acc_nxt;
  logic [2:0]  vcnt_nxt;
  logic [31:0] sh_nxt, un_nxt;
  logic [5:0]  klen_nxt;
  logic [15:0] vlen_nxt, left_nxt;
  logic        halt_nxt;
  cmd_t        c;
  logic        emit;

  always_comb begin
    pos_ext  = 33'(e_pos);
    next_ext = pos_ext + 33'd1;
    end_ext  = 33'(entries_end);
    remain   = (end_ext > next_ext) ? end_ext - next_ext : '0;
    acc_new  = e_acc | (32'(in_byte[6:0]) << (5'(7 * 32'(e_vcnt)) & 5'd31));
    vcnt_inc = e_vcnt + 3'd1;
    v        = acc_new;
    body_sum = 33'(un_r) + 33'(v);
    key_sum  = 33'(sh_r) + 33'(un_r);

    phase_nxt = e_phase;
    acc_nxt   = e_acc;
    vcnt_nxt  = e_vcnt;
    sh_nxt    = sh_r;
    un_nxt    = un_r;
    klen_nxt  = e_klen;
    vlen_nxt  = vlen_r;
    left_nxt  = in_start ? '0 : left_r;
    halt_nxt  = e_halt;
    emit      = 1'b0;
    key_we    = 1'b0;
    key_waddr = e_klen;
    c         = '0;
    c.op      = CMD_ERROR;
    c.last    = 1'b1;
    c.code    = ERR_HEADER;

    if (e_halt) begin
    end else if (e_phase == PH_SHARED || e_phase == PH_UNSHARED || e_phase == PH_VALLEN) begin
      if (next_ext - 33'd1 >= end_ext) begin
        if (!(e_phase == PH_SHARED && e_vcnt == '0)) begin
          emit = 1'b1;
          halt_nxt = 1'b1; phase_nxt = PH_SHARED; acc_nxt = '0; vcnt_nxt = '0;
        end
      end else begin
        logic hdone, herr;
        hdone = 1'b0;
        herr  = 1'b0;
        acc_nxt = acc_new;
        if (in_byte[7]) begin
          vcnt_nxt = vcnt_inc;
          if (vcnt_inc >= 3'd5) herr = 1'b1;
        end else begin
          acc_nxt = '0;
          vcnt_nxt = '0;
          unique case (e_phase)
            PH_SHARED:   begin sh_nxt = v; phase_nxt = PH_UNSHARED; end
            PH_UNSHARED: begin un_nxt = v; phase_nxt = PH_VALLEN; end
            default:     hdone = 1'b1;
          endcase
        end
        if (hdone) begin
          emit = 1'b1;
          if (body_sum > remain) begin
            c.code = ERR_OVERRUN; halt_nxt = 1'b1; phase_nxt = PH_SHARED;
          end else if (sh_r > 32'(e_klen)) begin
            c.code = ERR_SHARED; halt_nxt = 1'b1; phase_nxt = PH_SHARED;
          end else if (key_sum > 33'(KEY_MAX)) begin
            c.code = ERR_KEYOVF; halt_nxt = 1'b1; phase_nxt = PH_SHARED;
          end else begin
            vlen_nxt = v[15:0];
            klen_nxt = sh_r[5:0];
            c.op     = CMD_REPLAY;
            c.count  = sh_r[5:0];
            c.klen   = sh_r[5:0];
            c.vlen   = v[15:0];
            if (un_r != '0) begin
              phase_nxt = PH_KEY; left_nxt = un_r[15:0]; c.tail_done = 1'b0;
              if (sh_r == '0) emit = 1'b0;
            end else if (v != '0) begin
              phase_nxt = PH_VALUE; left_nxt = v[15:0]; c.tail_done = 1'b0;
              if (sh_r == '0) emit = 1'b0;
            end else begin
              phase_nxt = PH_SHARED; c.tail_done = 1'b1;
            end
          end
        end else if (herr || (next_ext >= end_ext)) begin
          emit = 1'b1;
          halt_nxt = 1'b1; phase_nxt = PH_SHARED; acc_nxt = '0; vcnt_nxt = '0;
        end
      end
    end else if (e_phase == PH_KEY) begin
      emit      = 1'b1;
      key_we    = acc;
      c.op      = CMD_KEY;
      c.data    = in_byte;
      c.idx     = 16'(e_klen);
      klen_nxt  = e_klen + 6'd1;
      left_nxt  = left_r - 16'd1;
      c.klen    = klen_nxt;
      c.vlen    = vlen_r;
      c.tail_done = 1'b0;
      if (left_nxt == '0) begin
        if (vlen_r != '0) begin
          phase_nxt = PH_VALUE; left_nxt = vlen_r;
        end else begin
          phase_nxt = PH_SHARED; c.tail_done = 1'b1;
        end
      end
    end else begin
      emit      = 1'b1;
      c.op      = CMD_VALUE;
      c.data    = in_byte;
      c.idx     = vlen_r - left_r;
      c.klen    = e_klen;
      c.vlen    = vlen_r;
      left_nxt  = left_r - 16'd1;
      c.tail_done = (left_nxt == '0);
      if (left_nxt == '0) phase_nxt = PH_SHARED;
    end
  end

  assign push     = acc && emit;
  assign push_cmd = c;
  assign pend_nxt = pend_r + 3'(push && c.op == CMD_REPLAY) - 3'(replay_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SHARED;
      acc_r   <= '0;
      vcnt_r  <= '0;
      sh_r    <= '0;
      un_r    <= '0;
      klen_r  <= '0;
      vlen_r  <= '0;
      left_r  <= '0;
      pos_r   <= '0;
      halt_r  <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      vcnt_r  <= vcnt_nxt;
      sh_r    <= sh_nxt;
      un_r    <= un_nxt;
      klen_r  <= klen_nxt;
      vlen_r  <= vlen_nxt;
      left_r  <= left_nxt;
      halt_r  <= halt_nxt;
      pos_r   <= (e_pos == '1) ? e_pos : e_pos + 1'b1;
    end
  end
endmodule

### rtl/pkbd_emitter.sv
// Back end: runs queued commands, replays the shared prefix from the key RAM,
// and drives the result register. Depends on pkbd_pkg.
module pkbd_emitter
  import pkbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head,
  input  logic       empty,
  output logic       pop,
  output logic [5:0] key_raddr,
  input  logic [7:0] key_rdata,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res
);
  typedef enum logic [1:0] { ST_IDLE, ST_READ, ST_SEND } state_t;

  state_t     state_r;
  logic [5:0] cnt_r;
  res_t       res_r;
  logic       vld_r;

  logic slot_free;
  assign slot_free = !vld_r || res_ready;
  assign res_valid = vld_r;
  assign res       = res_r;
  assign key_raddr = cnt_r;

  logic is_replay;
  assign is_replay = (head.op == CMD_REPLAY);

  always_comb begin
    pop = 1'b0;
    if (state_r == ST_IDLE && !empty && slot_free && !is_replay && !head.tail_done)
      pop = 1'b1;
    if (state_r == ST_SEND && slot_free && (!is_replay || cnt_r == head.count))
      pop = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      vld_r   <= 1'b0;
    end else begin
      if (res_ready) vld_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (!empty) begin
            if (is_replay) begin
              cnt_r   <= '0;
              state_r <= ST_READ;
            end else if (slot_free) begin
              vld_r      <= 1'b1;
              res_r      <= '0;
              res_r.last <= 1'b1;
              unique case (head.op)
                CMD_KEY, CMD_VALUE: begin
                  res_r.kind <= (head.op == CMD_KEY) ? KIND_KEY : KIND_VALUE;
                  res_r.data <= head.data;
                  res_r.idx  <= head.idx;
                  if (head.tail_done) begin
                    res_r.last <= 1'b0;
                    state_r    <= ST_SEND;
                    cnt_r      <= '0;
                  end
                end
                CMD_DONE: begin
                  res_r.kind <= KIND_DONE;
                  res_r.klen <= head.klen;
                  res_r.vlen <= head.vlen;
                end
                default: begin
                  res_r.kind <= KIND_ERROR;
                  res_r.code <= head.code;
                end
              endcase
            end
          end
        end
        ST_READ: begin
          state_r <= ST_SEND;
        end
        default: begin
          if (slot_free) begin
            vld_r  <= 1'b1;
            res_r  <= '0;
            if (!is_replay || cnt_r == head.count) begin
              // completion after a byte, or after a replay that ends the entry
              res_r.kind <= KIND_DONE;
              res_r.klen <= head.klen;
              res_r.vlen <= head.vlen;
              res_r.last <= 1'b1;
              state_r    <= ST_IDLE;
              if (is_replay && !head.tail_done) vld_r <= 1'b0;
            end else begin
              res_r.kind <= KIND_KEY;
              res_r.data <= key_rdata;
              res_r.idx  <= 16'(cnt_r);
              res_r.last <= (cnt_r + 6'd1 == head.count) && !head.tail_done;
              cnt_r      <= cnt_r + 6'd1;
              state_r    <= ST_READ;
            end
          end
        end
      endcase
    end
  end
endmodule

### rtl/prefix_key_block_decoder.sv
// Prefix-compressed key-value block decoder. One byte is taken per beat; a key
// or value byte gives one result after passing the command queue and the result
// register, plus a completion result if it ends the entry. A header that
// completes replays the shared prefix from the key RAM, each key byte by a RAM
// read then a result register write; a four-entry command queue lets header and
// value bytes keep running meanwhile, while key bytes wait until every queued
// replay has read the key RAM. Depends on pkbd_pkg.
module prefix_key_block_decoder
  import pkbd_pkg::*;
#(
  parameter int KEY_MAX     = KEY_MAX_DEF,
  parameter int REGION_BITS = REGION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  pkbd_in_if.sink      in_ch,
  pkbd_out_if.source   out_ch,
  pkbd_cfg_if.sink     cfg_ch
);
  logic [CFG_W-1:0] end_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_r <= '0;
    end else if (cfg_ch.valid) begin
      end_r <= cfg_ch.data;
    end
  end

  logic push, full, pop, empty, key_we, replay_done;
  cmd_t push_cmd, head;
  logic [5:0] key_waddr, key_raddr;
  logic [7:0] key_rdata;
  res_t res;

  assign replay_done = pop && (head.op == CMD_REPLAY);

  pkbd_parser #(.KEY_MAX(KEY_MAX), .REGION_BITS(REGION_BITS)) u_parser (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_byte(in_ch.data_byte), .in_start(in_ch.block_start),
    .entries_end(end_r),
    .push, .push_cmd, .q_full(full), .replay_done,
    .key_we, .key_waddr
  );

  pkbd_ram #(.WIDTH(8), .DEPTH(64)) u_keys (
    .clk, .we(key_we), .waddr(key_waddr), .wdata(in_ch.data_byte),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  pkbd_fifo #(.DEPTH(4)) u_fifo (
    .clk, .rst_n, .push, .push_cmd, .full, .pop, .head, .empty
  );

  pkbd_emitter u_emit (
    .clk, .rst_n, .head, .empty, .pop,
    .key_raddr, .key_rdata,
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res
  );

  assign out_ch.out_kind           = res.kind;
  assign out_ch.out_byte           = res.data;
  assign out_ch.item_index         = res.idx;
  assign out_ch.entry_key_length   = res.klen;
  assign out_ch.entry_value_length = res.vlen;
  assign out_ch.error_code         = res.code;
  assign out_ch.last_result        = res.last;
endmodule

### tb/sv/testbench.sv
// Testbench for prefix_key_block_decoder: directed table, then random blocks of entries.
// A built-in decoder model predicts every result beat; results are checked in order.
// Depends on pkbd_pkg and the channel interfaces in pkbd_if.sv.
module testbench;
  import pkbd_pkg::*;

  typedef enum int {PH_SHARED, PH_UNSHARED, PH_VALLEN, PH_KEY, PH_VALUE} phase_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] idx;
    logic [5:0]  klen;
    logic [15:0] vlen;
    logic [1:0]  code;
    logic        last;
  } result_t;

  typedef struct {
    bit         bs;
    logic [7:0] data;
    bit         typed;
    logic [1:0] kind;
    logic [1:0] code;
  } row_t;

  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;

  logic clk;
  logic rst_n;
  int   errors;
  int   quiet;
  bit   sender_gaps;

  result_t expected_q[$];
  logic [7:0] key_mem[64];
  int unsigned key_len, byte_pos, acc, vcount, sh_len, un_len, val_len, left, end_off;
  phase_t phase;
  bit halted;

  pkbd_in_if  in_if();
  pkbd_out_if out_if();
  pkbd_cfg_if cfg_if();

  prefix_key_block_decoder dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if), .cfg_ch(cfg_if)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic void push_result(int unsigned kind, int unsigned data, int unsigned idx,
                                      int unsigned klen, int unsigned vlen, int unsigned code);
    result_t r;
    r.kind = kind[1:0];
    r.data = data[7:0];
    r.idx  = idx[15:0];
    r.klen = klen[5:0];
    r.vlen = vlen[15:0];
    r.code = code[1:0];
    r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void raise_error(logic [1:0] code);
    halted = 1'b1;
    phase = PH_SHARED;
    acc = 0;
    vcount = 0;
    push_result(KIND_ERROR, 0, 0, 0, 0, code);
  endfunction

  function automatic void complete_entry();
    phase = PH_SHARED;
    push_result(KIND_DONE, 0, 0, key_len, val_len, 0);
  endfunction

  function automatic void finish_header(int unsigned sh, int unsigned un, int unsigned vl);
    longint unsigned nxt, remain;
    nxt = longint'(byte_pos) + 1;
    remain = (longint'(end_off) > nxt) ? longint'(end_off) - nxt : 0;
    if (longint'(un) + longint'(vl) > remain) begin
      raise_error(ERR_OVERRUN);
      return;
    end
    if (sh > key_len) begin
      raise_error(ERR_SHARED);
      return;
    end
    if (longint'(sh) + longint'(un) > KEY_MAX_DEF) begin
      raise_error(ERR_KEYOVF);
      return;
    end
    sh_len = sh;
    un_len = un;
    val_len = vl;
    key_len = sh;
    for (int i = 0; i < sh; i++) push_result(KIND_KEY, key_mem[i % 64], i, 0, 0, 0);
    if (un > 0) begin
      phase = PH_KEY;
      left = un;
    end else if (vl > 0) begin
      phase = PH_VALUE;
      left = vl;
    end else begin
      complete_entry();
    end
  endfunction

  function automatic void decode_byte(bit bs, logic [7:0] b);
    int prior_size;
    bit idle, header_done;
    int unsigned v;
    prior_size = expected_q.size();
    if (bs) begin
      key_len = 0;
      byte_pos = 0;
      phase = PH_SHARED;
      acc = 0;
      vcount = 0;
      left = 0;
      halted = 1'b0;
    end
    if (halted) begin
    end else if (phase inside {PH_SHARED, PH_UNSHARED, PH_VALLEN}) begin
      idle = (phase == PH_SHARED && vcount == 0);
      if (byte_pos >= end_off) begin
        if (!idle) raise_error(ERR_HEADER);
      end else begin
        header_done = 1'b0;
        acc |= 32'(b[6:0]) << ((7 * (vcount % 8)) % 32);
        if (b[7]) begin
          vcount++;
          if (vcount >= 5) raise_error(ERR_HEADER);
        end else begin
          v = acc;
          acc = 0;
          vcount = 0;
          if (phase == PH_SHARED) begin
            sh_len = v;
            phase = PH_UNSHARED;
          end else if (phase == PH_UNSHARED) begin
            un_len = v;
            phase = PH_VALLEN;
          end else begin
            header_done = 1'b1;
            finish_header(sh_len, un_len, v);
          end
        end
        if (!halted && !header_done && longint'(byte_pos) + 1 >= longint'(end_off))
          raise_error(ERR_HEADER);
      end
    end else if (phase == PH_KEY) begin
      key_mem[key_len % 64] = b;
      push_result(KIND_KEY, b, key_len % 64, 0, 0, 0);
      key_len = (key_len + 1) % 64;
      left--;
      if (left == 0) begin
        if (val_len > 0) begin
          phase = PH_VALUE;
          left = val_len;
        end else begin
          complete_entry();
        end
      end
    end else begin
      push_result(KIND_VALUE, b, val_len - left, 0, 0, 0);
      left--;
      if (left == 0) complete_entry();
    end
    if (byte_pos < 32'hFFFF) byte_pos++;
    if (expected_q.size() > prior_size) expected_q[$].last = 1'b1;
  endfunction

  task automatic send_byte(bit bs, logic [7:0] b);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.block_start <= bs;
    in_if.data_byte <= b;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    decode_byte(bs, b);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_end(logic [15:0] value);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    end_off = value;
  endtask

  task automatic send_varint(int unsigned v);
    while (v >= 128) begin
      send_byte(1'b0, 8'(v % 128) | 8'h80);
      v = v / 128;
    end
    send_byte(1'b0, 8'(v));
  endtask

  task automatic send_block(int entries, inout int sent);
    int kl, sh, un, vl;
    kl = 0;
    vl = $urandom_range(0, 3);
    send_byte(1'b1, 8'h00);
    send_varint(0);
    send_varint(vl);
    for (int i = 0; i < vl; i++) send_byte(1'b0, 8'($urandom));
    sent += 3 + vl;
    for (int e = 0; e < entries; e++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte($urandom_range(0, 15) == 0, 8'($urandom));
        sent++;
      end
      sh = $urandom_range(0, kl);
      un = ($urandom_range(0, 7) == 0) ? KEY_MAX_DEF - sh : $urandom_range(0, 4);
      vl = ($urandom_range(0, 11) == 0) ? $urandom_range(128, 200) : $urandom_range(0, 5);
      if ($urandom_range(0, 19) == 0) un = un + 1;
      send_varint(sh);
      send_varint(un);
      send_varint(vl);
      for (int i = 0; i < un + vl; i++) send_byte(1'b0, 8'($urandom));
      sent += 3 + un + vl;
      kl = (sh + un > KEY_MAX_DEF) ? kl : sh + un;
    end
  endtask

  row_t rows[$] = '{
    '{1, 8'h00, 0, KIND_KEY, 0}, '{0, 8'h03, 0, KIND_KEY, 0}, '{0, 8'h02, 0, KIND_KEY, 0},
    '{0, 8'h41, 1, KIND_KEY, 0}, '{0, 8'hFF, 1, KIND_KEY, 0}, '{0, 8'h00, 1, KIND_KEY, 0},
    '{0, 8'h80, 1, KIND_VALUE, 0}, '{0, 8'h7F, 1, KIND_DONE, 0},
    '{0, 8'h02, 0, KIND_KEY, 0}, '{0, 8'h01, 0, KIND_KEY, 0}, '{0, 8'h00, 0, KIND_KEY, 0},
    '{0, 8'h5A, 1, KIND_DONE, 0},
    '{0, 8'h05, 0, KIND_KEY, 0}, '{0, 8'h00, 0, KIND_KEY, 0},
    '{0, 8'h00, 1, KIND_ERROR, ERR_SHARED}, '{0, 8'h11, 0, KIND_KEY, 0},
    '{1, 8'h80, 0, KIND_KEY, 0}, '{0, 8'h80, 0, KIND_KEY, 0}, '{0, 8'h80, 0, KIND_KEY, 0},
    '{0, 8'h80, 0, KIND_KEY, 0}, '{0, 8'h80, 1, KIND_ERROR, ERR_HEADER},
    '{1, 8'h00, 0, KIND_KEY, 0}, '{0, 8'h00, 0, KIND_KEY, 0},
    '{0, 8'hFF, 0, KIND_KEY, 0}, '{0, 8'h7F, 1, KIND_ERROR, ERR_OVERRUN},
    '{1, 8'h00, 0, KIND_KEY, 0}, '{0, 8'h21, 0, KIND_KEY, 0},
    '{0, 8'h00, 1, KIND_ERROR, ERR_KEYOVF}
  };

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected beat kind", out_if.out_kind, 0);
      end else begin
        w = expected_q.pop_front();
        if (out_if.out_kind !== w.kind) report("kind", out_if.out_kind, w.kind);
        if (out_if.out_byte !== w.data) report("byte", out_if.out_byte, w.data);
        if (out_if.item_index !== w.idx) report("index", out_if.item_index, w.idx);
        if (out_if.entry_key_length !== w.klen)
          report("key length", out_if.entry_key_length, w.klen);
        if (out_if.entry_value_length !== w.vlen)
          report("value length", out_if.entry_value_length, w.vlen);
        if (out_if.error_code !== w.code) report("error code", out_if.error_code, w.code);
        if (out_if.last_result !== w.last) report("last", out_if.last_result, w.last);
      end
    end
  end

  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  initial begin
    int sent;
    int unsigned ends[6] = '{65535, 1, 24, 300, 40, 65535};
    errors = 0;
    quiet = 0;
    sent = 0;
    sender_gaps = 1'b1;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.block_start = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    key_len = 0; byte_pos = 0; acc = 0; vcount = 0; sh_len = 0; un_len = 0;
    val_len = 0; left = 0; end_off = 0; halted = 1'b0; phase = PH_SHARED;
    foreach (key_mem[i]) key_mem[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    write_end(16'd40);
    foreach (rows[r]) begin
      send_byte(rows[r].bs, rows[r].data);
      if (rows[r].typed && (expected_q.size() == 0 || expected_q[$].kind !== rows[r].kind ||
          expected_q[$].code !== rows[r].code))
        report("table row", 16'(r), rows[r].kind);
    end
    write_end(16'd0);
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'h81);

    for (int p = 0; sent < 340; p++) begin
      write_end(16'(ends[p % 6]));
      sender_gaps = (p % 4) != 3;
      send_block($urandom_range(1, 6), sent);
    end

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
